[hdl/tksum_pkg.sv]
package tksum_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int SUM_BITS     = 42;
  localparam int TOPK_BITS    = 11;
  localparam int ADDR_BITS    = 3;
  localparam int CAPACITY_DEF = 1024;
  localparam int TREE_FAN     = 32;

  localparam logic [TOPK_BITS-1:0] TOPK_RESET = TOPK_BITS'(1);

  // register select is the word address bit of paddr
  localparam logic REG_TOP_COUNT = 1'b0;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } tksum_state_t;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [VALUE_BITS-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] top_sum;
    logic [1:0]                 status;
  } out_item_t;

  typedef struct packed {
    logic                         ins;
    logic                         rem;
    logic signed [VALUE_BITS-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] val;
    logic                         ge;
  } cell_link_t;

  // node count of tree level l over n leaves
  function automatic int tree_count(int n, int l);
    int c;
    c = n;
    for (int s = 0; s < l; s++) begin
      c = (c + TREE_FAN - 1) / TREE_FAN;
    end
    return c;
  endfunction

  function automatic int tree_levels(int n);
    int c;
    int lv;
    lv = 1;
    c = (n + TREE_FAN - 1) / TREE_FAN;
    while (c > 1) begin
      c = (c + TREE_FAN - 1) / TREE_FAN;
      lv++;
    end
    return lv;
  endfunction

  function automatic logic [SUM_BITS-1:0] sext_sum(logic signed [VALUE_BITS-1:0] v);
    return SUM_BITS'(v);
  endfunction

endpackage

[hdl/tksum_cell.sv]
module tksum_cell (
  input  logic                                   clk,
  input  tksum_pkg::cell_cmd_t                   cmd,
  input  logic                                   occ,
  input  tksum_pkg::cell_link_t                  left_in,
  input  logic signed [tksum_pkg::VALUE_BITS-1:0] right_val,
  output tksum_pkg::cell_link_t                  link_out,
  output logic                                   hit,
  output logic signed [tksum_pkg::VALUE_BITS-1:0] val_q
);

  logic signed [tksum_pkg::VALUE_BITS-1:0] val_r, val_nxt;
  logic ge, le;

  assign ge  = occ && ($signed(val_r) >= $signed(cmd.value));
  assign le  = !occ || ($signed(val_r) <= $signed(cmd.value));
  assign hit = occ && (val_r == cmd.value);

  // insert: keep if at or above the new value, else take it or shift down
  // remove: cells at or past the target pull from the right neighbor
  always_comb begin
    val_nxt = val_r;
    if (cmd.ins && !ge) begin
      val_nxt = left_in.ge ? cmd.value : left_in.val;
    end else if (cmd.rem && le) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link_out.val = val_r;
  assign link_out.ge  = ge;
  assign val_q        = val_r;

endmodule

[hdl/tksum_tree.sv]
module tksum_tree #(
  parameter int N = tksum_pkg::CAPACITY_DEF,
  parameter int W = 2 * tksum_pkg::VALUE_BITS + 3
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] root
);

  localparam int Lvl = tksum_pkg::tree_levels(N);
  localparam int Fan = tksum_pkg::TREE_FAN;

  logic [W-1:0] node_r [Lvl][N];

  // registered OR tree; leaves are one-hot masked, so OR acts as a select
  for (genvar l = 0; l < Lvl; l++) begin : g_lvl
    localparam int NSrc = tksum_pkg::tree_count(N, l);
    localparam int NDst = tksum_pkg::tree_count(N, l + 1);
    for (genvar j = 0; j < N; j++) begin : g_node
      if (j < NDst) begin : g_used
        logic [W-1:0] or_v;
        if (l == 0) begin : g_first
          always_comb begin
            or_v = '0;
            for (int k = 0; k < Fan; k++) begin
              if (j * Fan + k < NSrc) begin
                or_v = or_v | leaf[(j * Fan + k < NSrc) ? j * Fan + k : 0];
              end
            end
          end
        end else begin : g_upper
          always_comb begin
            or_v = '0;
            for (int k = 0; k < Fan; k++) begin
              if (j * Fan + k < NSrc) begin
                or_v = or_v | node_r[l-1][(j * Fan + k < NSrc) ? j * Fan + k : 0];
              end
            end
          end
        end
        always_ff @(posedge clk) begin
          node_r[l][j] <= or_v;
        end
      end else begin : g_unused
        always_ff @(posedge clk) begin
          node_r[l][j] <= '0;
        end
      end
    end
  end

  assign root = node_r[Lvl-1][0];

endmodule

[hdl/top_k_sum_tracker_core.sv]
// Running top-K sum over a sorted multiset of signed values.
//
// Items arrive on in_valid/in_ready/in_item (func, item_value); each item
// yields one result on out_valid/out_ready/out_item (top_sum, status).
// K (top_count) is set over the APB port at byte address 0 and is taken only
// while the store is empty; prdata returns it.
//
// The store is a chain of CAPACITY cells kept in descending order. An item is
// taken in the idle cycle, then a registered OR tree of depth
// ceil(log32(CAPACITY)) brings back the cell values at ranks K and K+1 and
// whether the remove target is present; the update state then updates every
// cell and the sum at once and loads the output register. No new item is
// taken until that update is done, so items are never overlapped.
//
// Reset empties the store, clears the sum and sets K to 1; cell contents are
// not cleared. A result waits in the output register while the next item is
// taken and scanned; a stalled receiver holds the update cycle until the
// register frees up.
module top_k_sum_tracker_core #(
  parameter int CAPACITY = tksum_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tksum_pkg::in_item_t                   in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tksum_pkg::out_item_t                  out_item,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tksum_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int VB      = tksum_pkg::VALUE_BITS;
  localparam int SB      = tksum_pkg::SUM_BITS;
  localparam int KB      = tksum_pkg::TOPK_BITS;
  localparam int CntW    = $clog2(CAPACITY + 1);
  localparam int TreeLvl = tksum_pkg::tree_levels(CAPACITY);
  localparam int LvlW    = $clog2(TreeLvl + 1);
  localparam int LeafW   = 2 * VB + 3;

  tksum_pkg::tksum_state_t state_r, state_nxt;
  logic [LvlW-1:0]   cnt_r, cnt_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [SB-1:0]     sum_r, sum_nxt;
  logic [KB-1:0]     top_count_r;
  logic [1:0]        func_r;
  logic signed [VB-1:0] val_r;
  logic              out_valid_r;
  tksum_pkg::out_item_t out_item_r;

  logic in_acc, out_free, apply_go, full, cfg_wr;
  logic present, ka_v, kb_v;
  logic signed [VB-1:0] ka_val, kb_val;
  logic [1:0] status;
  logic [LeafW-1:0] root;

  tksum_pkg::cell_cmd_t  cmd;
  tksum_pkg::cell_link_t links [CAPACITY];
  logic signed [VB-1:0]  vals  [CAPACITY];
  logic                  hits  [CAPACITY];
  logic [LeafW-1:0]      leaf  [CAPACITY];

  // ---------------- handshake and sequencing ----------------
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign full     = (count_r == CntW'(CAPACITY));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tksum_pkg::S_IDLE:  if (in_valid) state_nxt = tksum_pkg::S_SCAN;
      tksum_pkg::S_SCAN:  if (cnt_r == '0) state_nxt = tksum_pkg::S_APPLY;
      tksum_pkg::S_APPLY: if (out_free) state_nxt = tksum_pkg::S_IDLE;
      default:            state_nxt = tksum_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    apply_go = 1'b0;
    unique case (state_r)
      tksum_pkg::S_IDLE:  in_ready = 1'b1;
      tksum_pkg::S_SCAN:  ;
      tksum_pkg::S_APPLY: apply_go = out_free;
      default:            ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = LvlW'(TreeLvl - 1);
    end else if (state_r == tksum_pkg::S_SCAN && cnt_r != '0) begin
      cnt_nxt = cnt_r - LvlW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tksum_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_item.func;
      val_r  <= in_item.item_value;
    end
  end

  // ---------------- cell chain ----------------
  assign cmd.ins   = apply_go && (func_r == tksum_pkg::FN_INSERT) && !full;
  assign cmd.rem   = apply_go && (func_r == tksum_pkg::FN_REMOVE) && present;
  assign cmd.value = val_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ, at_k1, at_k;
    tksum_pkg::cell_link_t left_in;
    logic signed [VB-1:0]  right_val;

    assign occ   = (CntW'(i) < count_r);
    assign at_k1 = occ && (32'(top_count_r) == i + 1);
    assign at_k  = occ && (32'(top_count_r) == i);

    if (i == 0) begin : g_head
      assign left_in.val = '0;
      assign left_in.ge  = 1'b1;
    end else begin : g_body
      assign left_in = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_next
      assign right_val = vals[i+1];
    end

    tksum_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ),
      .left_in   (left_in),
      .right_val (right_val),
      .link_out  (links[i]),
      .hit       (hits[i]),
      .val_q     (vals[i])
    );

    assign leaf[i] = {hits[i], at_k1, at_k1 ? vals[i] : VB'(0), at_k, at_k ? vals[i] : VB'(0)};
  end

  tksum_tree #(
    .N (CAPACITY),
    .W (LeafW)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  assign present = root[LeafW-1];
  assign ka_v    = root[2*VB+1];
  assign ka_val  = root[2*VB:VB+1];
  assign kb_v    = root[VB];
  assign kb_val  = root[VB-1:0];

  // ---------------- sum, count, status ----------------
  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    status    = tksum_pkg::ST_DONE;
    case (func_r)
      tksum_pkg::FN_INSERT: begin
        if (full) begin
          status = tksum_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CntW'(1);
          // lands above rank K: gain it, lose the old rank-K value
          if (top_count_r != '0 && (!ka_v || $signed(ka_val) < $signed(val_r))) begin
            sum_nxt = sum_r + tksum_pkg::sext_sum(val_r)
                      - (ka_v ? tksum_pkg::sext_sum(ka_val) : SB'(0));
          end
        end
      end
      tksum_pkg::FN_REMOVE: begin
        if (!present) begin
          status = tksum_pkg::ST_ABSENT;
        end else begin
          count_nxt = count_r - CntW'(1);
          // removed copy sat in the top K: drop it, promote rank K+1
          if (top_count_r != '0 && (!ka_v || $signed(ka_val) <= $signed(val_r))) begin
            sum_nxt = sum_r - tksum_pkg::sext_sum(val_r)
                      + (kb_v ? tksum_pkg::sext_sum(kb_val) : SB'(0));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (apply_go) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_item_r.top_sum <= sum_nxt;
      out_item_r.status  <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= tksum_pkg::TOPK_RESET;
    end else if (cfg_wr && paddr[2] == tksum_pkg::REG_TOP_COUNT && count_r == '0) begin
      top_count_r <= pwdata[KB-1:0];
    end
  end

  assign prdata = (paddr[2] == tksum_pkg::REG_TOP_COUNT) ? {{(32-KB){1'b0}}, top_count_r} : '0;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("store count beyond capacity");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> sum_r == '0)
    else $error("nonzero sum with empty store");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tksum_pkg::S_APPLY))
    else $error("result appeared outside the update cycle");

  a_k_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && count_r != '0) |=> $stable(top_count_r))
    else $error("K changed while store not empty");

endmodule
